### sv/fmab_pkg.sv
package fmab_pkg;

    // Field widths
    localparam int COORD_W = 16;
    localparam int COLOR_W = 32;
    localparam int ADDR_W  = 24;
    localparam int START_W = 12;
    localparam int END_W   = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Stream payload widths
    localparam int IN_TDATA_W  = 2 * COORD_W + 3 * COLOR_W;
    localparam int OUT_TDATA_W = ADDR_W + COLOR_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y_START  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X_END    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y_END    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURING_ON  = 3'd5;

    // Register reset values
    localparam logic [END_W-1:0] END_RESET   = 13'd4096;
    localparam logic [END_W-1:0] WIDTH_RESET = 13'd4096;

    // Alpha value that makes the source opaque
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [START_W-1:0] clip_x_start;
        logic [START_W-1:0] clip_y_start;
        logic [END_W-1:0]   clip_x_end;
        logic [END_W-1:0]   clip_y_end;
        logic [END_W-1:0]   surface_width;
        logic               texturing_on;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] fragment_color;
        logic [COLOR_W-1:0] texel_color;
        logic [COLOR_W-1:0] dest_color;
    } t_frag;

    // Tested and modulated fragment, handed to the blend stage
    typedef struct packed {
        logic               pass;
        logic [COLOR_W-1:0] src_color;
        logic [COLOR_W-1:0] dest_color;
        logic [ADDR_W-1:0]  pixel_address;
    } t_mod;

endpackage

### sv/fmab_test_mod.sv
// Clip and alpha tests, texture modulate and pixel address
module fmab_test_mod #(
    parameter int COORD_BITS = 12
) (
    input  fmab_pkg::t_cfg  i_cfg,
    input  fmab_pkg::t_frag i_frag,
    output fmab_pkg::t_mod  o_mod
);

    localparam int CMP_W = fmab_pkg::COORD_W + 1;
    localparam int LIM_W = COORD_BITS + 1;
    localparam int PRD_W = COORD_BITS + LIM_W;
    localparam int SUM_W = (PRD_W > fmab_pkg::ADDR_W ? PRD_W : fmab_pkg::ADDR_W) + 1;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(1) << COORD_BITS;

    logic signed [CMP_W-1:0] x_s;
    logic signed [CMP_W-1:0] y_s;
    logic [CMP_W-1:0] x_end;
    logic [CMP_W-1:0] y_end;
    logic [CMP_W-1:0] w_ext;
    logic [CMP_W-1:0] x_end_sat;
    logic [CMP_W-1:0] y_end_sat;
    logic [CMP_W-1:0] w_sat;
    logic             in_rect;
    logic             frag_alpha_ok;
    logic             tex_alpha_ok;
    logic [fmab_pkg::COLOR_W-1:0] modulated;
    logic [15:0]      chan_prod [4];
    logic [PRD_W-1:0] row_offset;
    logic [SUM_W-1:0] addr_sum;

    // Clip rectangle, ends saturated to the coordinate space
    always_comb begin
        x_s = $signed({i_frag.pixel_x[fmab_pkg::COORD_W-1], i_frag.pixel_x});
        y_s = $signed({i_frag.pixel_y[fmab_pkg::COORD_W-1], i_frag.pixel_y});
        x_end = CMP_W'(i_cfg.clip_x_end);
        y_end = CMP_W'(i_cfg.clip_y_end);
        w_ext = CMP_W'(i_cfg.surface_width);
        x_end_sat = (x_end > LIMIT) ? LIMIT : x_end;
        y_end_sat = (y_end > LIMIT) ? LIMIT : y_end;
        w_sat     = (w_ext > LIMIT) ? LIMIT : w_ext;
        in_rect = (x_s >= $signed(CMP_W'(i_cfg.clip_x_start)))
               && (y_s >= $signed(CMP_W'(i_cfg.clip_y_start)))
               && (x_s <  $signed(x_end_sat))
               && (y_s <  $signed(y_end_sat));
    end

    // Texture modulate, one 8x8 product per channel
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            chan_prod[k] = 16'(i_frag.fragment_color[8*k +: 8]) *
                           16'(i_frag.texel_color[8*k +: 8]);
            modulated[8*k +: 8] = chan_prod[k][15:8];
        end
    end

    // Address: row times width plus column, inside the clip rectangle both fit COORD_BITS
    always_comb begin
        row_offset = PRD_W'(i_frag.pixel_y[COORD_BITS-1:0]) * PRD_W'(w_sat[LIM_W-1:0]);
        addr_sum   = SUM_W'(row_offset) + SUM_W'(i_frag.pixel_x[COORD_BITS-1:0]);
    end

    always_comb begin
        frag_alpha_ok = (i_frag.fragment_color[31:24] != 8'd0);
        tex_alpha_ok  = !i_cfg.texturing_on || (i_frag.texel_color[31:24] != 8'd0);
        o_mod.pass          = in_rect && frag_alpha_ok && tex_alpha_ok;
        o_mod.src_color     = i_cfg.texturing_on ? modulated : i_frag.fragment_color;
        o_mod.dest_color    = i_frag.dest_color;
        o_mod.pixel_address = addr_sum[fmab_pkg::ADDR_W-1:0];
    end

endmodule

### sv/fmab_blend.sv
// Alpha blend against the framebuffer colour, rejected items give zeros
module fmab_blend (
    input  fmab_pkg::t_mod              i_mod,
    output logic                        o_write_enable,
    output logic [fmab_pkg::ADDR_W-1:0]  o_pixel_address,
    output logic [fmab_pkg::COLOR_W-1:0] o_out_color
);

    logic [7:0]  alpha;
    logic [7:0]  alpha_inv;
    logic [16:0] mix [4];
    logic [16:0] rounded [4];
    logic [fmab_pkg::COLOR_W-1:0] blended;

    // Per channel (s*a + d*(255-a)) / 255; x/255 = (x + 1 + (x >> 8)) >> 8 for x < 2^16
    always_comb begin
        alpha     = i_mod.src_color[31:24];
        alpha_inv = 8'hFF - alpha;
        for (int k = 0; k < 4; k++) begin
            mix[k] = 17'(16'(i_mod.src_color[8*k +: 8]) * 16'(alpha))
                   + 17'(16'(i_mod.dest_color[8*k +: 8]) * 16'(alpha_inv));
            rounded[k] = mix[k] + 17'd1 + 17'(mix[k][16:8]);
            blended[8*k +: 8] = rounded[k][15:8];
        end
    end

    always_comb begin
        o_write_enable  = i_mod.pass;
        o_pixel_address = i_mod.pass ? i_mod.pixel_address : '0;
        if (!i_mod.pass) begin
            o_out_color = '0;
        end else if (alpha == fmab_pkg::ALPHA_OPAQUE) begin
            o_out_color = i_mod.src_color;
        end else begin
            o_out_color = blended;
        end
    end

endmodule

### sv/fragment_modulate_alpha_blend.sv
// Per-fragment back end: clip test, alpha tests, texture modulate and alpha blend.
// Input channel (i_s_*): one fragment per item, position, fragment colour, texel
// and the framebuffer colour at that pixel. Output channel (o_m_*): one result
// per fragment, in order: tuser is the write flag, tdata the pixel address and
// the colour to store. A rejected fragment gives a zero flag, address and colour.
// Configuration: i_cfg_wr_en writes i_cfg_wdata into register i_cfg_index
// (clip start x/y, clip end x/y, surface width, texturing on); write it only
// while no fragment is in flight.
// Pipeline: the result passes through three registers (input, modulate and
// address, blend). Throughput: one fragment per cycle while the receiver is
// ready; the stage with the 8x8 products and the address multiply sets the clock.
// Each stage advances when the next one is empty or moving, so a stalled
// receiver fills the bubbles first and then drops o_s_tready.
// Reset clears all stages and loads the register reset values.
module fragment_modulate_alpha_blend #(
    parameter int COORD_BITS = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [fmab_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fmab_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Fragment input
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // pixel_x, pixel_y, fragment_color, texel_color, dest_color
    input  logic [fmab_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // Result output
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // write_enable
    output logic                              o_m_tuser,
    // pixel_address, out_color
    output logic [fmab_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    fmab_pkg::t_cfg  r_cfg;
    fmab_pkg::t_frag r_a;
    fmab_pkg::t_mod  r_b;
    fmab_pkg::t_mod  n_b;
    logic r_a_valid;
    logic r_b_valid;
    logic r_c_valid;
    logic r_c_we;
    logic [fmab_pkg::ADDR_W-1:0]  r_c_addr;
    logic [fmab_pkg::COLOR_W-1:0] r_c_color;
    logic n_c_we;
    logic [fmab_pkg::ADDR_W-1:0]  n_c_addr;
    logic [fmab_pkg::COLOR_W-1:0] n_c_color;
    logic a_ready;
    logic b_ready;
    logic c_ready;
    logic in_take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_x_start  <= '0;
            r_cfg.clip_y_start  <= '0;
            r_cfg.clip_x_end    <= fmab_pkg::END_RESET;
            r_cfg.clip_y_end    <= fmab_pkg::END_RESET;
            r_cfg.surface_width <= fmab_pkg::WIDTH_RESET;
            r_cfg.texturing_on  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                fmab_pkg::CFG_CLIP_X_START:
                    r_cfg.clip_x_start <= i_cfg_wdata[fmab_pkg::START_W-1:0];
                fmab_pkg::CFG_CLIP_Y_START:
                    r_cfg.clip_y_start <= i_cfg_wdata[fmab_pkg::START_W-1:0];
                fmab_pkg::CFG_CLIP_X_END:    r_cfg.clip_x_end    <= i_cfg_wdata;
                fmab_pkg::CFG_CLIP_Y_END:    r_cfg.clip_y_end    <= i_cfg_wdata;
                fmab_pkg::CFG_SURFACE_WIDTH: r_cfg.surface_width <= i_cfg_wdata;
                fmab_pkg::CFG_TEXTURING_ON:  r_cfg.texturing_on  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Stage handshake: a stage moves when the next one is empty or moving
    assign c_ready    = !r_c_valid || i_m_tready;
    assign b_ready    = !r_b_valid || c_ready;
    assign a_ready    = !r_a_valid || b_ready;
    assign o_s_tready = a_ready;
    assign in_take    = i_s_tvalid && a_ready;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) r_a_valid <= i_s_tvalid;
            if (b_ready) r_b_valid <= r_a_valid;
            if (c_ready) r_c_valid <= r_b_valid;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a.pixel_x        <= i_s_tdata[15:0];
            r_a.pixel_y        <= i_s_tdata[31:16];
            r_a.fragment_color <= i_s_tdata[63:32];
            r_a.texel_color    <= i_s_tdata[95:64];
            r_a.dest_color     <= i_s_tdata[127:96];
        end
    end

    fmab_test_mod #(
        .COORD_BITS (COORD_BITS)
    ) u_test_mod (
        .i_cfg  (r_cfg),
        .i_frag (r_a),
        .o_mod  (n_b)
    );

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b <= n_b;
        end
    end

    fmab_blend u_blend (
        .i_mod           (r_b),
        .o_write_enable  (n_c_we),
        .o_pixel_address (n_c_addr),
        .o_out_color     (n_c_color)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (c_ready && r_b_valid) begin
            r_c_we    <= n_c_we;
            r_c_addr  <= n_c_addr;
            r_c_color <= n_c_color;
        end
    end

    assign o_m_tvalid = r_c_valid;
    assign o_m_tuser  = r_c_we;
    assign o_m_tdata  = {r_c_color, r_c_addr};

    // A rejected item carries an all-zero payload
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && !r_c_we) |-> (r_c_addr == '0 && r_c_color == '0))
        else $error("rejected item with nonzero payload");

    // An accepted item always lands in the input stage
    a_take_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_a_valid)
        else $error("accepted item lost at input stage");

    // An item in the middle stage moves on when the result stage can take it
    a_b_to_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && c_ready) |=> r_c_valid)
        else $error("item lost between modulate and blend stages");

    // A stalled result stays valid
    a_c_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && !i_m_tready) |=> (r_c_valid && $stable(r_c_color)))
        else $error("stalled result dropped or changed");

endmodule
